FILE: hdl/assert_macros.svh
// Assertion macros for the mailbox RTL.
// Checks compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/emb_pkg.sv
// Types and constants for the event mailbox.
// No dependencies.
`default_nettype none

package emb_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // opcodes
    localparam logic [1:0] OP_POST    = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_CANCEL  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESYNC_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_TYPE2  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_CONN   = 2'd2;

    // completion codes
    localparam logic COMPL_DELIVERED = 1'b0;
    localparam logic COMPL_CANCELLED = 1'b1;

    localparam logic signed [31:0] ID_NONE = -32'sd1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         event_type;
        logic signed [31:0] contact_id;
        logic [31:0]        connection_id;
        logic [7:0]         event_type2;
        logic signed [31:0] extra_contact_id;
    } t_in_word;

    typedef struct packed {
        logic               completion;
        logic               overflow_notice;
        logic [7:0]         out_type;
        logic signed [31:0] out_contact_id;
        logic [31:0]        out_connection_id;
        logic [7:0]         out_type2;
        logic signed [31:0] out_extra_contact_id;
    } t_out_word;

    // one queued event
    typedef struct packed {
        logic [7:0]         event_type;
        logic signed [31:0] contact_id;
        logic [31:0]        connection_id;
        logic [7:0]         event_type2;
        logic signed [31:0] extra_contact_id;
    } t_entry;

    // broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: hdl/emb_cell.sv
// One FIFO cell of the mailbox queue chain: occupancy bit plus one event.
// Depends on emb_pkg.
`default_nettype none

module emb_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  emb_pkg::t_cell_ctl  i_ctl,
    input  wire                 i_head,
    input  wire                 i_prev_occ,
    input  wire                 i_next_occ,
    input  emb_pkg::t_entry     i_next_data,
    input  emb_pkg::t_entry     i_push_data,
    output logic                o_occ,
    output emb_pkg::t_entry     o_data
);

    logic            r_occ;
    logic            n_occ;
    emb_pkg::t_entry r_data;
    emb_pkg::t_entry n_data;
    logic            w_take;

    // a push lands in the first free cell; with a flush it lands at the head
    assign w_take = i_ctl.flush ? i_head : (!r_occ && i_prev_occ);

    always_comb begin
        n_occ  = r_occ;
        n_data = r_data;
        priority if (i_ctl.pop) begin
            n_occ  = i_next_occ;
            n_data = i_next_data;
        end else if (i_ctl.push) begin
            if (w_take) begin
                n_occ  = 1'b1;
                n_data = i_push_data;
            end else begin
                n_occ  = r_occ && !i_ctl.flush;
            end
        end else if (i_ctl.flush) begin
            n_occ = 1'b0;
        end else begin
            // idle cycle: hold
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_occ  = r_occ;
    assign o_data = r_data;

endmodule

`default_nettype wire

FILE: hdl/event_mailbox_with_overflow_unit.sv
// Event mailbox with overflow collapse: a chain of QUEUE_DEPTH cells, head in cell 0.
// When a command yields a result word, it strobes on o_valid the cycle after start is taken.
// Throughput 1 word per cycle; busy stays low, since every command is one push,
// one shift of the cell chain or one flag update. The receiver cannot stall.
// Synchronous active-low reset empties the queue and clears flags, o_valid and config registers.
// Depends on emb_pkg, emb_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module event_mailbox_with_overflow_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // command channel
    input  wire                               start,
    output logic                              busy,
    input  emb_pkg::t_in_word                 i_in,
    // result channel
    output logic                              o_valid,
    output emb_pkg::t_out_word                o_out,
    // configuration write port
    input  wire                               i_cfg_we,
    input  wire [emb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [emb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration registers
    logic [7:0]  r_resync_type;
    logic [7:0]  r_null_type2;
    logic [31:0] r_null_conn;

    // control state
    logic r_pending, n_pending;
    logic r_overflow, n_overflow;
    logic r_valid, n_valid;
    emb_pkg::t_out_word r_out, n_out;

    // cell chain
    emb_pkg::t_cell_ctl w_ctl;
    emb_pkg::t_entry    w_push_data;
    emb_pkg::t_entry    w_data [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_occ;

    logic w_accept;
    logic w_empty;
    logic w_full;
    logic w_resync;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_empty  = !w_occ[0];
    assign w_full   = w_occ[QUEUE_DEPTH-1];
    assign w_resync = (i_in.event_type == r_resync_type);

    assign w_push_data.event_type       = i_in.event_type;
    assign w_push_data.contact_id       = i_in.contact_id;
    assign w_push_data.connection_id    = i_in.connection_id;
    assign w_push_data.event_type2      = i_in.event_type2;
    assign w_push_data.extra_contact_id = i_in.extra_contact_id;

    // Cell g shifts toward g-1 on a pop; a push fills the first empty cell.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic            w_prev_occ;
        logic            w_next_occ;
        emb_pkg::t_entry w_next_data;

        if (g == 0) begin : g_head
            assign w_prev_occ = 1'b1;
        end else begin : g_body
            assign w_prev_occ = w_occ[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next_occ  = 1'b0;
            assign w_next_data = '0;
        end else begin : g_link
            assign w_next_occ  = w_occ[g+1];
            assign w_next_data = w_data[g+1];
        end

        emb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_head      ((g == 0) ? 1'b1 : 1'b0),
            .i_prev_occ  (w_prev_occ),
            .i_next_occ  (w_next_occ),
            .i_next_data (w_next_data),
            .i_push_data (w_push_data),
            .o_occ       (w_occ[g]),
            .o_data      (w_data[g])
        );
    end

    // command decode
    always_comb begin
        w_ctl      = '0;
        n_pending  = r_pending;
        n_overflow = r_overflow;
        n_valid    = 1'b0;
        n_out      = r_out;
        if (w_accept) begin
            unique case (i_in.opcode)
                emb_pkg::OP_POST: begin
                    // a resync event always empties the queue first
                    w_ctl.flush = w_resync;
                    priority if (r_overflow) begin
                        // dropped while overflowed
                    end else if (r_pending) begin
                        // hand straight to the waiting requester
                        n_pending                  = 1'b0;
                        n_valid                    = 1'b1;
                        n_out.completion           = emb_pkg::COMPL_DELIVERED;
                        n_out.overflow_notice      = 1'b0;
                        n_out.out_type             = i_in.event_type;
                        n_out.out_contact_id       = i_in.contact_id;
                        n_out.out_connection_id    = i_in.connection_id;
                        n_out.out_type2            = i_in.event_type2;
                        n_out.out_extra_contact_id = i_in.extra_contact_id;
                    end else if (w_full && !w_resync) begin
                        // collapse the queue into one overflow notice
                        w_ctl.flush = 1'b1;
                        n_overflow  = 1'b1;
                    end else begin
                        w_ctl.push = 1'b1;
                    end
                end
                emb_pkg::OP_REQUEST: begin
                    priority if (r_pending) begin
                        // duplicate request ignored
                    end else if (r_overflow) begin
                        n_overflow                 = 1'b0;
                        n_valid                    = 1'b1;
                        n_out.completion           = emb_pkg::COMPL_DELIVERED;
                        n_out.overflow_notice      = 1'b1;
                        n_out.out_type             = r_resync_type;
                        n_out.out_contact_id       = emb_pkg::ID_NONE;
                        n_out.out_connection_id    = r_null_conn;
                        n_out.out_type2            = r_null_type2;
                        n_out.out_extra_contact_id = emb_pkg::ID_NONE;
                    end else if (!w_empty) begin
                        w_ctl.pop                  = 1'b1;
                        n_valid                    = 1'b1;
                        n_out.completion           = emb_pkg::COMPL_DELIVERED;
                        n_out.overflow_notice      = 1'b0;
                        n_out.out_type             = w_data[0].event_type;
                        n_out.out_contact_id       = w_data[0].contact_id;
                        n_out.out_connection_id    = w_data[0].connection_id;
                        n_out.out_type2            = w_data[0].event_type2;
                        n_out.out_extra_contact_id = w_data[0].extra_contact_id;
                    end else begin
                        n_pending = 1'b1;
                    end
                end
                emb_pkg::OP_CANCEL: begin
                    if (r_pending) begin
                        n_pending  = 1'b0;
                        n_valid    = 1'b1;
                        n_out      = '0;
                        n_out.completion = emb_pkg::COMPL_CANCELLED;
                    end
                end
                default: begin
                    // unused opcode: no effect
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending     <= 1'b0;
            r_overflow    <= 1'b0;
            r_valid       <= 1'b0;
            r_resync_type <= '0;
            r_null_type2  <= '0;
            r_null_conn   <= '0;
        end else begin
            r_pending  <= n_pending;
            r_overflow <= n_overflow;
            r_valid    <= n_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    emb_pkg::CFG_RESYNC_TYPE: r_resync_type <= i_cfg_data[7:0];
                    emb_pkg::CFG_NULL_TYPE2:  r_null_type2  <= i_cfg_data[7:0];
                    emb_pkg::CFG_NULL_CONN:   r_null_conn   <= i_cfg_data;
                    default: begin
                        // no register at this index
                    end
                endcase
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

    // pending request and overflow exclude each other
    `ASSERT_ALWAYS(a_pend_ovf_excl, i_clk, i_rst_n, !(r_pending && r_overflow))
    // a waiting requester means the queue is empty
    `ASSERT_IMPL(a_pend_empty, i_clk, i_rst_n, r_pending, w_empty)
    // overflow leaves the queue collapsed
    `ASSERT_IMPL(a_ovf_empty, i_clk, i_rst_n, r_overflow, w_empty)
    // a result word only follows an accepted command
    `ASSERT_IMPL(a_valid_cause, i_clk, i_rst_n, o_valid, $past(w_accept))

endmodule

`default_nettype wire
